// ===== src/efsd_pkg.sv =====
package efsd_pkg;

  // Widths fixed by the item fields and the configuration register.
  localparam int DATA_W          = 32;
  localparam int CFG_W           = 7;
  localparam int MAX_SERVERS_DEF = 64;

  localparam logic [DATA_W-1:0] SAT_MAX = {DATA_W{1'b1}};

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_DROP,
    OP_TRIM,
    OP_INSERT
  } cell_op_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INSERT
  } state_t;

  // Control word shared by all cells.
  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] key;
  } cell_ctrl_t;

  // What one cell hands to its neighbour further down the chain.
  typedef struct packed {
    logic              valid;
    logic              keep;
    logic [DATA_W-1:0] val;
  } cell_link_t;

  // Addition that sticks at the maximum instead of wrapping.
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? SAT_MAX : s[DATA_W-1:0];
  endfunction

endpackage

// ===== src/efsd_cell.sv =====
module efsd_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  efsd_pkg::cell_ctrl_t ctrl,
  input  efsd_pkg::cell_link_t prev,
  input  logic                 next_valid,
  output efsd_pkg::cell_link_t link_out,
  output logic [efsd_pkg::DATA_W-1:0] tail_val
);

  logic [efsd_pkg::DATA_W-1:0] val;
  logic                        valid;
  logic                        keep;
  logic                        last;

  // The chain is sorted in descending order with the valid entries first,
  // so a cell keeps its place on insert when it holds a value not below the key.
  assign keep = valid && (val >= ctrl.key);
  assign last = valid && !next_valid;

  assign link_out.valid = valid;
  assign link_out.keep  = keep;
  assign link_out.val   = val;

  // Only the last valid cell, which holds the earliest finish time, shows its value.
  assign tail_val = last ? val : '0;

  // Cell update for the broadcast operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        efsd_pkg::OP_DROP: begin
          valid <= valid && (val > ctrl.key);
        end
        efsd_pkg::OP_TRIM: begin
          if (last) begin
            valid <= 1'b0;
          end
        end
        efsd_pkg::OP_INSERT: begin
          if (!keep) begin
            if (prev.keep) begin
              val   <= ctrl.key;
              valid <= 1'b1;
            end else begin
              val   <= prev.val;
              valid <= prev.valid;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/earliest_free_server_dispatcher_core.sv =====
// Earliest-free-server dispatcher.
// Input channel (in_valid/in_ready) carries one job item: arrival_time and
// job_duration. Output channel (out_valid/out_ready) returns one item per job:
// its finish_time and the running makespan. The configuration channel
// (cfg_valid/cfg_ready) writes server_count and is always ready; write it
// only while no job is in flight.
// Finish times of busy servers live in a chain of MAX_SERVERS cells kept in
// descending order. Each item runs through a drop, a decide and an insert
// step: expired entries are dropped in every cell at the accepting edge, the
// decide step picks the new finish time (from the arrival or, when every
// server in use is busy, from the earliest busy server, found through an OR
// over the cells, whose entry it trims), and the insert step adds it with a
// one-place shift along the chain; the next item waits for that insert.
// The result sits in an output register; while the receiver stalls, the next
// item is still accepted and processed up to its insert step.
// Reset empties the chain, clears the makespan and sets server_count to one.
module earliest_free_server_dispatcher_core #(
  parameter int MAX_SERVERS = efsd_pkg::MAX_SERVERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [efsd_pkg::DATA_W-1:0]  arrival_time,
  input  logic [efsd_pkg::DATA_W-1:0]  job_duration,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [efsd_pkg::DATA_W-1:0]  finish_time,
  output logic [efsd_pkg::DATA_W-1:0]  makespan,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [efsd_pkg::CFG_W-1:0]   cfg_data
);

  localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  efsd_pkg::state_t             state;
  efsd_pkg::state_t             state_next;
  efsd_pkg::cell_ctrl_t         ctrl;
  efsd_pkg::cell_link_t         link [MAX_SERVERS+1];
  logic [efsd_pkg::DATA_W-1:0]  tail [MAX_SERVERS];
  logic [MAX_SERVERS:0]         valid_ext;
  logic [MAX_SERVERS-1:0]       valid_vec;
  logic [efsd_pkg::DATA_W-1:0]  earliest;
  logic [efsd_pkg::CFG_W-1:0]   server_count;
  logic [efsd_pkg::DATA_W-1:0]  arrival;
  logic [efsd_pkg::DATA_W-1:0]  duration;
  logic [efsd_pkg::DATA_W-1:0]  new_finish;
  logic [efsd_pkg::DATA_W-1:0]  new_finish_next;
  logic [efsd_pkg::DATA_W-1:0]  latest_finish;
  logic [efsd_pkg::DATA_W-1:0]  latest_next;
  logic [31:0]                  sc_ext;
  logic [31:0]                  idx32;
  logic [IW-1:0]                full_idx;
  logic                         full;
  logic                         in_fire;
  logic                         out_free;

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == efsd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= efsd_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      server_count <= cfg_data;
    end
  end

  // Index of the cell whose valid bit says every server in use is busy.
  always_comb begin
    sc_ext = 32'(server_count);
    if (sc_ext == 32'd0) begin
      idx32 = 32'd0;
    end else if (sc_ext > 32'(MAX_SERVERS)) begin
      idx32 = 32'(MAX_SERVERS - 1);
    end else begin
      idx32 = sc_ext - 32'd1;
    end
    full_idx = idx32[IW-1:0];
  end

  // The cell chain; the head link makes the first cell take the key.
  assign link[0] = '{valid: 1'b0, keep: 1'b1, val: '0};
  assign valid_ext[MAX_SERVERS] = 1'b0;

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    efsd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev       (link[i]),
      .next_valid (valid_ext[i+1]),
      .link_out   (link[i+1]),
      .tail_val   (tail[i])
    );
    assign valid_ext[i] = link[i+1].valid;
    assign valid_vec[i] = link[i+1].valid;
  end

  // Earliest busy finish time: only the last valid cell contributes.
  always_comb begin
    earliest = '0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      earliest = earliest | tail[i];
    end
  end

  assign full = valid_vec[full_idx];

  // Sequencer: cell operation, next state and the new finish time.
  always_comb begin
    state_next      = state;
    ctrl.op         = efsd_pkg::OP_NONE;
    ctrl.key        = new_finish;
    new_finish_next = new_finish;
    case (state)
      efsd_pkg::ST_IDLE: begin
        ctrl.key = arrival_time;
        if (in_fire) begin
          ctrl.op    = efsd_pkg::OP_DROP;
          state_next = efsd_pkg::ST_DECIDE;
        end
      end
      efsd_pkg::ST_DECIDE: begin
        if (full) begin
          new_finish_next = efsd_pkg::sat_add(earliest, duration);
          ctrl.op         = efsd_pkg::OP_TRIM;
        end else begin
          new_finish_next = efsd_pkg::sat_add(arrival, duration);
        end
        state_next = efsd_pkg::ST_INSERT;
      end
      efsd_pkg::ST_INSERT: begin
        if (out_free) begin
          ctrl.op    = efsd_pkg::OP_INSERT;
          state_next = efsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = efsd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      arrival  <= arrival_time;
      duration <= job_duration;
    end
    new_finish <= new_finish_next;
  end

  assign latest_next = (new_finish > latest_finish) ? new_finish : latest_finish;

  // Makespan and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      latest_finish <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (state == efsd_pkg::ST_INSERT && out_free) begin
        latest_finish <= latest_next;
        out_valid     <= 1'b1;
        finish_time   <= new_finish;
        makespan      <= latest_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Valid entries always form an unbroken run from the first cell.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + {{MAX_SERVERS{1'b0}}, 1'b1}))
    else $error("cell chain has a gap in its valid entries");

  // An accepted item always moves on to the decide step.
  a_accept_step: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == efsd_pkg::ST_DECIDE))
    else $error("accepted item did not reach the decide step");

  // An insert step with a free output register delivers a result.
  a_insert_out: assert property (@(posedge clk) disable iff (rst)
    (state == efsd_pkg::ST_INSERT && out_free) |=> out_valid)
    else $error("insert step did not load the output register");

  // The makespan never falls below the finish time that goes with it.
  a_makespan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (makespan >= finish_time))
    else $error("makespan below finish time");

endmodule
